// File: hw/rtl/tdd_pkg.sv
package tdd_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned KEY_W = 16;
  localparam int unsigned PH_W  = 10;
  localparam int unsigned CNT_W = 32;

  // Operation codes; the spare code is answered as a plain status.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SUSP  = 3'd3;
  localparam logic [2:0] OP_RESUM = 3'd4;
  localparam logic [2:0] OP_TERM  = 3'd5;
  localparam logic [2:0] OP_QUERY = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_CMD   = 2'd2;

  // Command status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RUNNING = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_BADDIV  = 3'd3;
  localparam logic [2:0] ST_NOTFND  = 3'd4;

  // Priority codes and the first slot of each upward search range.
  localparam logic [1:0] PRIO_TOP  = 2'd0;
  localparam logic [1:0] PRIO_HIGH = 2'd1;
  localparam logic [1:0] PRIO_LOW  = 2'd3;
  localparam int unsigned RANGE_LO0 = 0;
  localparam int unsigned RANGE_LO1 = 1;
  localparam int unsigned RANGE_LO2 = 5;

  // One slot table entry as held in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PH_W-1:0]  divider;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count;
    logic             first;
    logic             skip;
    logic             kill;
  } slot_ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MOD,
    S_FIRE,
    S_DONE,
    S_RESP
  } tdd_state_e;

endpackage

// File: hw/rtl/tdd_slot_mem.sv
module tdd_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  tdd_pkg::slot_ent_t  wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output tdd_pkg::slot_ent_t  rdata_o
);
  import tdd_pkg::*;

  slot_ent_t mem_q [DEPTH];
  slot_ent_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tdd_rem.sv
module tdd_rem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tdd_pkg::PH_W-1:0] dividend_i,
  input  logic [tdd_pkg::PH_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [tdd_pkg::PH_W-1:0] rem_o
);
  import tdd_pkg::*;

  localparam int unsigned CW = $clog2(PH_W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PH_W-1:0] dvd_q, dvd_d;
  logic [PH_W-1:0] rem_q, rem_d;
  logic [PH_W-1:0] dsr_q, dsr_d;
  logic [PH_W:0]   trial;
  logic [PH_W:0]   diff;

  // One restoring remainder step per cycle, most significant bit first.
  always_comb begin
    trial  = {rem_q, dvd_q[PH_W-1]};
    diff   = trial - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[PH_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, dsr_q}) ? diff[PH_W-1:0] : trial[PH_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(PH_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: hw/rtl/tick_divided_task_dispatcher.sv
// Channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------------------
// request   | in_valid_i / in_stall_o      | operation_i task_id_i divider_i loop_limit_i
//           |                              | priority_req_i
// result    | out_valid_o / out_stall_i    | kind_o slot_o status_o first_run_o run_count_o
//           |                              | last_o
// config    | cfg_we_i                     | cfg_wdata_i (base rate)
//
// One request is handled at a time. A command walks the slot memory, reading and then
// evaluating each slot in turn, and stops at the key or the last slot. A tick reads and
// evaluates every slot, checks each eligible slot against its divider with the bit-serial
// remainder unit, fires each slot whose remainder is zero, and then finishes.
// The used bits are flip-flops cleared by reset; the memory needs no clearing pass.
// A stalled result is held in the output register and the walk waits on it.
module tick_divided_task_dispatcher #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                operation_i,
  input  logic [tdd_pkg::KEY_W-1:0] task_id_i,
  input  logic [tdd_pkg::PH_W-1:0]  divider_i,
  input  logic [tdd_pkg::CNT_W-1:0] loop_limit_i,
  input  logic [1:0]                priority_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [3:0]                slot_o,
  output logic [2:0]                status_o,
  output logic                      first_run_o,
  output logic [tdd_pkg::CNT_W-1:0] run_count_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [tdd_pkg::PH_W-1:0]  cfg_wdata_i
);
  import tdd_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  tdd_state_e state_q, state_d;

  // Control and payload registers.
  logic [SLOTS-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic              lo_fnd_q, lo_fnd_d, hi_fnd_q, hi_fnd_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [PH_W-1:0]   base_rate_q;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        op_q;
  logic [KEY_W-1:0]  key_q;
  logic [PH_W-1:0]   div_q;
  logic [CNT_W-1:0]  lim_q;
  logic [1:0]        prio_q;
  slot_ent_t         ent_q, ent_d;
  logic [1:0]        kind_q, kind_d;
  logic [IDX_W-1:0]  oslot_q, oslot_d;
  logic [2:0]        status_q, status_d;
  logic              first_q, first_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              last_q, last_d;

  // Memory and remainder unit hookup.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  slot_ent_t         mem_wdata;
  slot_ent_t         mem_rdata;
  logic              mod_start;
  logic              mod_done;
  logic [PH_W-1:0]   mod_rem;

  // Shared decode.
  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              last_idx;
  logic              hit;
  logic              tick_check;
  logic [IDX_W-1:0]  rng_lo;
  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  cnt_inc;
  logic [PH_W-1:0]   ph_inc;
  logic [IDX_W+3:0]  slot_ext;

  tdd_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  tdd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (phase_q),
    .divisor_i  (mem_rdata.divider),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Handshake and common decode.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_idx   = (idx_q == IDX_LAST);
  assign hit        = used_q[idx_q] && (mem_rdata.key == key_q);
  assign tick_check = used_q[idx_q] && !mem_rdata.kill && !mem_rdata.skip &&
                      (mem_rdata.divider != '0);
  assign cnt_inc    = (&ent_q.count) ? ent_q.count : ent_q.count + 1'b1;
  assign ph_inc     = phase_q + 1'b1;
  assign free_ok    = ((prio_q != PRIO_LOW) && lo_fnd_q) || hi_fnd_q;
  assign free_idx   = ((prio_q != PRIO_LOW) && lo_fnd_q) ? lo_q : hi_q;

  // Start of the upward search range for the requested priority.
  always_comb begin
    case (prio_q)
      PRIO_TOP:  rng_lo = IDX_W'(RANGE_LO0);
      PRIO_HIGH: rng_lo = IDX_W'(RANGE_LO1);
      default:   rng_lo = IDX_W'(RANGE_LO2);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_TICK || operation_i == OP_START ||
              operation_i == OP_STOP || operation_i == OP_SUSP ||
              operation_i == OP_RESUM || operation_i == OP_TERM ||
              operation_i == OP_QUERY) begin
            state_d = S_READ;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (op_q == OP_TICK) begin
          if (tick_check) begin
            state_d = S_MOD;
          end else begin
            state_d = last_idx ? S_DONE : S_READ;
          end
        end else if (hit || last_idx) begin
          state_d = S_RESP;
        end else begin
          state_d = S_READ;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            state_d = S_FIRE;
          end else begin
            state_d = last_idx ? S_DONE : S_READ;
          end
        end
      end
      S_FIRE: begin
        if (out_free) begin
          state_d = last_idx ? S_DONE : S_READ;
        end
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      S_RESP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory writes and result loading.
  always_comb begin
    used_d    = used_q;
    idx_d     = idx_q;
    found_d   = found_q;
    lo_d      = lo_q;
    lo_fnd_d  = lo_fnd_q;
    hi_d      = hi_q;
    hi_fnd_d  = hi_fnd_q;
    phase_d   = phase_q;
    ent_d     = ent_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = ent_q;
    mod_start = 1'b0;
    out_load  = 1'b0;
    kind_d    = kind_q;
    oslot_d   = oslot_q;
    status_d  = status_q;
    first_d   = first_q;
    count_d   = count_q;
    last_d    = last_q;

    unique case (state_q)
      S_IDLE: begin
        idx_d    = '0;
        found_d  = 1'b0;
        lo_fnd_d = 1'b0;
        hi_fnd_d = 1'b0;
      end
      S_READ: ;
      S_EVAL: begin
        ent_d = mem_rdata;
        if (op_q == OP_TICK) begin
          if (used_q[idx_q] && mem_rdata.kill) begin
            used_d[idx_q] = 1'b0;
          end
          mod_start = tick_check;
          if (!tick_check && !last_idx) idx_d = idx_q + 1'b1;
        end else begin
          // Track free slots for a start while looking for the key.
          if (!used_q[idx_q]) begin
            hi_d     = idx_q;
            hi_fnd_d = 1'b1;
            if (!lo_fnd_q && idx_q >= rng_lo) begin
              lo_d     = idx_q;
              lo_fnd_d = 1'b1;
            end
          end
          found_d = hit;
          if (!hit && !last_idx) idx_d = idx_q + 1'b1;
        end
      end
      S_MOD: begin
        if (mod_done && mod_rem != '0 && !last_idx) idx_d = idx_q + 1'b1;
      end
      S_FIRE: begin
        if (out_free) begin
          out_load  = 1'b1;
          kind_d    = KIND_FIRED;
          oslot_d   = idx_q;
          status_d  = ST_OK;
          first_d   = ent_q.first;
          count_d   = ent_q.count;
          last_d    = 1'b0;
          mem_we    = 1'b1;
          mem_wdata = ent_q;
          mem_wdata.first = 1'b0;
          mem_wdata.count = cnt_inc;
          if (ent_q.limit != '0 && cnt_inc >= ent_q.limit) used_d[idx_q] = 1'b0;
          if (!last_idx) idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_DONE;
          oslot_d  = '0;
          status_d = ST_OK;
          first_d  = 1'b0;
          count_d  = '0;
          last_d   = 1'b1;
          phase_d  = (ph_inc >= base_rate_q) ? '0 : ph_inc;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_CMD;
          oslot_d  = '0;
          status_d = ST_OK;
          first_d  = 1'b0;
          count_d  = '0;
          last_d   = 1'b1;
          case (op_q)
            OP_START: begin
              if (found_q) begin
                status_d = ST_RUNNING;
                oslot_d  = idx_q;
              end else if (!free_ok) begin
                status_d = ST_NOFREE;
              end else if (div_q == '0) begin
                status_d = ST_BADDIV;
              end else begin
                oslot_d           = free_idx;
                used_d[free_idx]  = 1'b1;
                mem_we            = 1'b1;
                mem_waddr         = free_idx;
                mem_wdata.key     = key_q;
                mem_wdata.divider = div_q;
                mem_wdata.limit   = lim_q;
                mem_wdata.count   = '0;
                mem_wdata.first   = 1'b1;
                mem_wdata.skip    = 1'b0;
                mem_wdata.kill    = 1'b0;
              end
            end
            OP_STOP, OP_SUSP, OP_RESUM, OP_TERM, OP_QUERY: begin
              if (!found_q) begin
                status_d = ST_NOTFND;
              end else begin
                oslot_d = idx_q;
                case (op_q)
                  OP_STOP: used_d[idx_q] = 1'b0;
                  OP_SUSP: begin
                    mem_we         = 1'b1;
                    mem_wdata.skip = 1'b1;
                  end
                  OP_RESUM: begin
                    mem_we         = 1'b1;
                    mem_wdata.skip = 1'b0;
                  end
                  OP_TERM: begin
                    mem_we         = 1'b1;
                    mem_wdata.kill = 1'b1;
                  end
                  default: count_d = ent_q.count;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      phase_q     <= '0;
      base_rate_q <= PH_W'(1000);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      lo_fnd_q    <= 1'b0;
      hi_fnd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      lo_fnd_q    <= lo_fnd_d;
      hi_fnd_q    <= hi_fnd_d;
      if (cfg_we_i) base_rate_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      key_q  <= task_id_i;
      div_q  <= divider_i;
      lim_q  <= loop_limit_i;
      prio_q <= priority_req_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    ent_q    <= ent_d;
    kind_q   <= kind_d;
    oslot_q  <= oslot_d;
    status_q <= status_d;
    first_q  <= first_d;
    count_q  <= count_d;
    last_q   <= last_d;
  end

  // Result ports; slots report their low four bits.
  assign slot_ext    = {4'b0000, oslot_q};
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_ext[3:0];
  assign status_o    = status_q;
  assign first_run_o = first_q;
  assign run_count_o = count_q;
  assign last_o      = last_q;

  // The memory is only written while firing a slot or answering a command.
  a_mem_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_FIRE || state_q == S_RESP))
    else $error("slot memory written outside fire or response");

  // The remainder unit reports only while the walk waits on it.
  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("remainder result arrived outside the wait state");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  // After a tick finishes the phase lies below the base rate or has wrapped.
  a_phase_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (phase_q < base_rate_q || phase_q == '0))
    else $error("phase did not wrap at the base rate");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import tdd_pkg::*;

  // The spare operation code is not named in the package.
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int unsigned NSLOT = 16;
  localparam int unsigned SETTLE = 300;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       slot;
    logic [2:0]       status;
    logic             first_run;
    logic [CNT_W-1:0] run_count;
    logic             last;
  } dispatch_res_t;

  // Scoreboard: tracks the slot table and phase, and holds the expected results.
  class dispatch_sb;
    bit               used [NSLOT];
    logic [KEY_W-1:0] key [NSLOT];
    logic [PH_W-1:0]  divider [NSLOT];
    logic [CNT_W-1:0] limit [NSLOT];
    logic [CNT_W-1:0] count [NSLOT];
    bit               first [NSLOT];
    bit               skip [NSLOT];
    bit               kill [NSLOT];
    logic [PH_W-1:0]  phase;
    logic [PH_W-1:0]  base_rate;
    dispatch_res_t    due_q [$];
    int               errors;

    function new();
      foreach (used[i]) used[i] = 0;
      phase = '0;
      base_rate = 10'd1000;
      errors = 0;
    endfunction

    function void push(logic [1:0] k, int s, logic [2:0] st, bit f,
                       logic [CNT_W-1:0] c, bit l);
      dispatch_res_t r;
      r.kind = k;
      r.slot = s[3:0];
      r.status = st;
      r.first_run = f;
      r.run_count = c;
      r.last = l;
      due_q.push_back(r);
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
        if (used[i] && key[i] == k) return i;
      return -1;
    endfunction

    // Walk the priority ranges from the requested one down to the lowest.
    function int free_slot(logic [1:0] prio);
      int lo;
      for (int p = prio; p < 4; p++) begin
        if (p == PRIO_LOW) begin
          for (int i = NSLOT - 1; i >= 0; i--)
            if (!used[i]) return i;
        end else begin
          lo = (p == PRIO_TOP) ? RANGE_LO0 : (p == PRIO_HIGH) ? RANGE_LO1 : RANGE_LO2;
          for (int i = lo; i < NSLOT; i++)
            if (!used[i]) return i;
        end
      end
      return -1;
    endfunction

    function void note_request(logic [2:0] op, logic [KEY_W-1:0] k, logic [PH_W-1:0] dv,
                               logic [CNT_W-1:0] lim, logic [1:0] prio);
      int s;
      logic [PH_W:0] nxt;
      if (op == OP_TICK) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!used[i]) continue;
          if (kill[i]) begin
            used[i] = 0;
            continue;
          end
          if (skip[i] || divider[i] == 0 || (phase % divider[i]) != 0) continue;
          push(KIND_FIRED, i, ST_OK, first[i], count[i], 0);
          first[i] = 0;
          if (count[i] != '1) count[i]++;
          if (limit[i] != 0 && count[i] >= limit[i]) used[i] = 0;
        end
        nxt = phase + 1;
        phase = nxt[PH_W-1:0];
        if (phase >= base_rate) phase = '0;
        push(KIND_DONE, 0, ST_OK, 0, 0, 1);
      end else if (op == OP_START) begin
        s = find_key(k);
        if (s >= 0) begin
          push(KIND_CMD, s, ST_RUNNING, 0, 0, 1);
          return;
        end
        s = free_slot(prio);
        if (s < 0) begin
          push(KIND_CMD, 0, ST_NOFREE, 0, 0, 1);
        end else if (dv == 0) begin
          push(KIND_CMD, 0, ST_BADDIV, 0, 0, 1);
        end else begin
          used[s] = 1;
          key[s] = k;
          divider[s] = dv;
          limit[s] = lim;
          count[s] = '0;
          first[s] = 1;
          skip[s] = 0;
          kill[s] = 0;
          push(KIND_CMD, s, ST_OK, 0, 0, 1);
        end
      end else if (op == OP_SPARE) begin
        push(KIND_CMD, 0, ST_OK, 0, 0, 1);
      end else begin
        s = find_key(k);
        if (s < 0) begin
          push(KIND_CMD, 0, ST_NOTFND, 0, 0, 1);
          return;
        end
        case (op)
          OP_STOP: used[s] = 0;
          OP_SUSP: skip[s] = 1;
          OP_RESUM: skip[s] = 0;
          OP_TERM: kill[s] = 1;
          default: ;
        endcase
        push(KIND_CMD, s, ST_OK, 0, (op == OP_QUERY) ? count[s] : '0, 1);
      end
    endfunction

    function void check_result(dispatch_res_t got);
      dispatch_res_t want;
      if (due_q.size() == 0) begin
        $error("unexpected result kind=%0d slot=%0d", got.kind, got.slot);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.slot != want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.first_run != want.first_run) begin
        $error("first_run: expected %0d, got %0d", want.first_run, got.first_run);
        errors++;
      end
      if (got.run_count != want.run_count) begin
        $error("run_count: expected %0d, got %0d", want.run_count, got.run_count);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [2:0]       operation_i = OP_TICK;
  logic [KEY_W-1:0] task_id_i = '0;
  logic [PH_W-1:0]  divider_i = '0;
  logic [CNT_W-1:0] loop_limit_i = '0;
  logic [1:0]       priority_req_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b1;
  logic [1:0]       kind_o;
  logic [3:0]       slot_o;
  logic [2:0]       status_o;
  logic             first_run_o;
  logic [CNT_W-1:0] run_count_o;
  logic             last_o;
  logic             cfg_we_i = 1'b0;
  logic [PH_W-1:0]  cfg_wdata_i = '0;

  dispatch_sb sb = new();
  bit         long_hold = 0;
  bit         no_idle = 0;

  always #6 clk_i = ~clk_i;

  tick_divided_task_dispatcher #(.SLOTS(NSLOT)) dut (.*);

  // Present one request, wait for it to be taken, then idle for the drawn gap.
  task automatic send_request(logic [2:0] op, logic [KEY_W-1:0] k, logic [PH_W-1:0] dv,
                              logic [CNT_W-1:0] lim, logic [1:0] prio);
    int gap;
    operation_i <= op;
    task_id_i <= k;
    divider_i <= dv;
    loop_limit_i <= lim;
    priority_req_i <= prio;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, k, dv, lim, prio);
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write the base rate once the block has drained.
  task automatic write_base_rate(logic [PH_W-1:0] rate);
    in_valid_i <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_wdata_i <= rate;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.base_rate = rate;
  endtask

  // Random request, mostly on a small pool of keys so that lookups hit.
  task automatic send_random();
    int pick;
    logic [2:0] op;
    logic [KEY_W-1:0] k;
    logic [PH_W-1:0] dv;
    logic [CNT_W-1:0] lim;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_TICK;
    else if (pick < 60) op = OP_START;
    else if (pick < 70) op = OP_STOP;
    else if (pick < 76) op = OP_SUSP;
    else if (pick < 82) op = OP_RESUM;
    else if (pick < 90) op = OP_TERM;
    else if (pick < 98) op = OP_QUERY;
    else op = OP_SPARE;
    k = ($urandom_range(0, 9) < 8) ? KEY_W'(100 + $urandom_range(0, 31)) : KEY_W'($urandom);
    pick = $urandom_range(0, 19);
    dv = (pick == 0) ? '0 : (pick < 15) ? PH_W'($urandom_range(1, 4))
                                        : PH_W'($urandom_range(1, 1000));
    pick = $urandom_range(0, 9);
    lim = (pick < 6) ? '0 : (pick < 9) ? CNT_W'($urandom_range(1, 5)) : CNT_W'($urandom);
    send_request(op, k, dv, lim, 2'($urandom_range(0, 3)));
  endtask

  // Result side: random stall before each result, with one long hold-off on request.
  initial begin : result_sink
    int wait_cycles;
    dispatch_res_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        wait_cycles = 400;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.kind = kind_o;
      got.slot = slot_o;
      got.status = status_o;
      got.first_run = first_run_o;
      got.run_count = run_count_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Main sequence.
  initial begin : stimulus
    logic [PH_W-1:0] rates [4] = '{10'd1, 10'd7, 10'd1000, 10'd3};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_base_rate(10'd1000);

    // Directed: every operation, the field extremes and the start error order.
    send_request(OP_START, 16'hFFFF, 10'd1, 32'd0, 2'd0);
    send_request(OP_START, 16'hFFFF, 10'd2, 32'd0, 2'd1);
    send_request(OP_START, 16'd101, 10'd0, 32'd0, 2'd0);
    send_request(OP_START, 16'd102, 10'd1000, 32'hFFFF_FFFF, 2'd1);
    send_request(OP_START, 16'd103, 10'd2, 32'd3, 2'd2);
    send_request(OP_START, 16'd104, 10'd3, 32'd0, 2'd3);
    repeat (3) send_request(OP_TICK, 16'd0, 10'd0, 32'd0, 2'd0);
    send_request(OP_SUSP, 16'hFFFF, 10'd0, 32'd0, 2'd0);
    send_request(OP_TICK, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF, 2'd3);
    send_request(OP_QUERY, 16'hFFFF, 10'd0, 32'd0, 2'd0);
    send_request(OP_RESUM, 16'hFFFF, 10'd0, 32'd0, 2'd0);
    send_request(OP_TERM, 16'd103, 10'd0, 32'd0, 2'd0);
    send_request(OP_TICK, 16'd0, 10'd0, 32'd0, 2'd0);
    send_request(OP_STOP, 16'd102, 10'd0, 32'd0, 2'd0);
    send_request(OP_QUERY, 16'd102, 10'd0, 32'd0, 2'd0);
    send_request(OP_SPARE, 16'd0, 10'd0, 32'd0, 2'd0);
    // Fill the table, then ask once more so that no slot is free.
    for (int i = 0; i < 14; i++) send_request(OP_START, KEY_W'(110 + i), 10'd5, 32'd0, 2'd3);
    send_request(OP_START, 16'd130, 10'd0, 32'd0, 2'd2);
    send_request(OP_TICK, 16'd0, 10'd0, 32'd0, 2'd0);

    // Random phases, each under its own base rate.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_base_rate(rates[ph - 1]);
      for (int n = 0; n < 35; n++) begin
        no_idle = (n >= 20 && n < 28);
        if (ph == 2 && n == 10) long_hold = 1;
        send_random();
      end
      no_idle = 0;
    end
    in_valid_i <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #(12 * 1500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tdd_pkg.sv
hw/rtl/tdd_slot_mem.sv
hw/rtl/tdd_rem.sv
hw/rtl/tick_divided_task_dispatcher.sv
tb/sv/tb_top.sv
